// ===== rtl/ordinal_date_decoder_core_macros.svh =====
// Assertion macros for the checker file.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef ORDINAL_DATE_DECODER_CORE_MACROS_SVH
`define ORDINAL_DATE_DECODER_CORE_MACROS_SVH

// Same-cycle implication
`define ODD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ODD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/odd_pkg.sv =====
`timescale 1ns / 1ps

package odd_pkg;

  // ASCII codes of interest
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned NUM_MONTHS = 12;

  localparam logic [11:0] YEAR_BASE_1900 = 12'd1900;
  localparam logic [11:0] YEAR_BASE_2000 = 12'd2000;

  // Last day of year of each month in a common year
  localparam logic [9:0] MONTH_END [NUM_MONTHS] = '{
    10'd31,  10'd59,  10'd90,  10'd120, 10'd151, 10'd181,
    10'd212, 10'd243, 10'd273, 10'd304, 10'd334, 10'd365
  };

  // Decoded date as it leaves the decode logic
  typedef struct packed {
    logic        date_valid;
    logic [11:0] year_value;
    logic [3:0]  month_value;
    logic [4:0]  day_of_month;
  } odd_result_t;

  // Last day of year of a month, with the leap day added from February on
  function automatic logic [9:0] month_end(input logic [3:0] idx, input logic leap);
    logic [9:0] base;
    base = MONTH_END[idx];
    if (leap && (idx != 4'd0)) begin
      base = base + 10'd1;
    end
    return base;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

// ===== rtl/odd_decode.sv =====
`timescale 1ns / 1ps

module odd_decode (
  input  logic [7:0]         century_char_i,
  input  logic [7:0]         year_tens_char_i,
  input  logic [7:0]         year_units_char_i,
  input  logic [7:0]         day_hundreds_char_i,
  input  logic [7:0]         day_tens_char_i,
  input  logic [7:0]         day_units_char_i,
  output odd_pkg::odd_result_t result_o
);
  import odd_pkg::*;

  logic       century_space;
  logic       chars_ok;
  logic [3:0] cen_dig, yt_dig, yu_dig, dh_dig, dt_dig, du_dig;
  logic [6:0] year_in_cent;
  logic [11:0] year;
  logic       leap;
  logic [9:0] doy;
  logic [3:0] month;
  logic [9:0] prev_end;
  logic       found;
  logic [9:0] mday;

  // Character checks and digit values
  assign century_space = (century_char_i == CHAR_SPACE);
  assign chars_ok = (century_space || is_digit(century_char_i)) &&
                    is_digit(year_tens_char_i) && is_digit(year_units_char_i) &&
                    is_digit(day_hundreds_char_i) && is_digit(day_tens_char_i) &&
                    is_digit(day_units_char_i);

  assign cen_dig = century_char_i[3:0];
  assign yt_dig  = year_tens_char_i[3:0];
  assign yu_dig  = year_units_char_i[3:0];
  assign dh_dig  = day_hundreds_char_i[3:0];
  assign dt_dig  = day_tens_char_i[3:0];
  assign du_dig  = day_units_char_i[3:0];

  // Year; both century bases are multiples of four, so leap follows YY
  assign year_in_cent = 7'(yt_dig * 7'd10) + 7'(yu_dig);
  assign year = (century_space ? YEAR_BASE_1900
                               : YEAR_BASE_2000 + 12'(cen_dig * 12'd100))
              + 12'(year_in_cent);
  assign leap = (year_in_cent[1:0] == 2'b00);

  // Day of year
  assign doy = 10'(dh_dig * 10'd100) + 10'(dt_dig * 10'd10) + 10'(du_dig);

  // Month search: parallel compares, the earliest matching month wins
  always_comb begin
    month    = '0;
    prev_end = '0;
    found    = 1'b0;
    for (int m = NUM_MONTHS - 1; m >= 0; m--) begin
      if (doy <= month_end(4'(m), leap)) begin
        month    = 4'(m + 1);
        prev_end = (m == 0) ? 10'd0 : month_end(4'(m - 1), leap);
        found    = 1'b1;
      end
    end
  end

  assign mday = doy - prev_end;

  // Result, zeroed when not valid
  always_comb begin
    result_o = '0;
    if (chars_ok && (doy != 10'd0) && found) begin
      result_o.date_valid   = 1'b1;
      result_o.year_value   = year;
      result_o.month_value  = month;
      result_o.day_of_month = mday[4:0];
    end
  end

endmodule

// ===== rtl/ordinal_date_decoder_core.sv =====
`timescale 1ns / 1ps
// Ordinal date decoder: turns a six-character CYYDDD field into year,
// month and day of month.
// Input channel: in_valid_i / in_stall_o with the six ASCII characters.
// A transfer happens on a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i with date_valid_o and the
// decoded fields; fields are zero when date_valid_o is low.
// Path from input transfer to result valid: input register, then result
// register, with the decode logic between them.
// Throughput: one date per cycle; both registers advance every cycle
// while the receiver does not stall.
// Stall: a held result stays stable; an empty input register still takes
// one more item, after which in_stall_o follows out_stall_i.
// Reset: rst_ni (async, active low) empties both registers; no item is
// lost or produced by reset release.
module ordinal_date_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  century_char_i,
  input  logic [7:0]  year_tens_char_i,
  input  logic [7:0]  year_units_char_i,
  input  logic [7:0]  day_hundreds_char_i,
  input  logic [7:0]  day_tens_char_i,
  input  logic [7:0]  day_units_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        date_valid_o,
  output logic [11:0] year_value_o,
  output logic [3:0]  month_value_o,
  output logic [4:0]  day_of_month_o
);
  import odd_pkg::*;

  logic        in_valid_q;
  logic [7:0]  cen_q, yt_q, yu_q, dh_q, dt_q, du_q;
  logic        out_valid_q;
  odd_result_t res_d, res_q;
  logic        out_load;
  logic        in_load;

  // Stage advance: result register frees when empty or taken
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load    = !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      cen_q <= century_char_i;
      yt_q  <= year_tens_char_i;
      yu_q  <= year_units_char_i;
      dh_q  <= day_hundreds_char_i;
      dt_q  <= day_tens_char_i;
      du_q  <= day_units_char_i;
    end
  end

  // Decode logic
  odd_decode u_decode (
    .century_char_i      (cen_q),
    .year_tens_char_i    (yt_q),
    .year_units_char_i   (yu_q),
    .day_hundreds_char_i (dh_q),
    .day_tens_char_i     (dt_q),
    .day_units_char_i    (du_q),
    .result_o            (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign date_valid_o   = res_q.date_valid;
  assign year_value_o   = res_q.year_value;
  assign month_value_o  = res_q.month_value;
  assign day_of_month_o = res_q.day_of_month;

endmodule

// ===== rtl/odd_checker.sv =====
`timescale 1ns / 1ps
`include "ordinal_date_decoder_core_macros.svh"

module odd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        date_valid_o,
  input logic [11:0] year_value_o,
  input logic [3:0]  month_value_o,
  input logic [4:0]  day_of_month_o
);

  // A good date has fields in range
  `ODD_ASSERT_NOW(a_valid_range, out_valid_o && date_valid_o, (month_value_o >= 4'd1) && (month_value_o <= 4'd12) && (day_of_month_o != 5'd0) && (year_value_o >= 12'd1900), "valid date with out-of-range field")

  // A rejected date carries zero fields
  `ODD_ASSERT_NOW(a_invalid_zero, out_valid_o && !date_valid_o, (year_value_o == 12'd0) && (month_value_o == 4'd0) && (day_of_month_o == 5'd0), "invalid date with nonzero field")

  // An accepted item reaches the output if the receiver does not stall
  `ODD_ASSERT_NEXT(a_latency, (in_valid_i && !in_stall_o) ##1 !out_stall_i, out_valid_o, "accepted transfer did not reach output")

  // A stalled result holds
  `ODD_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(date_valid_o) && $stable(year_value_o) && $stable(month_value_o) && $stable(day_of_month_o), "stalled result changed")

endmodule

bind ordinal_date_decoder_core odd_checker u_odd_checker (.*);

// ===== bench/ordinal_date_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the ordinal date decoder, predicts each decoded
// date on input transfer and compares it with the result transfers in order.
module ordinal_date_checker
  import odd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  century_char_i,
  input  logic [7:0]  year_tens_char_i,
  input  logic [7:0]  year_units_char_i,
  input  logic [7:0]  day_hundreds_char_i,
  input  logic [7:0]  day_tens_char_i,
  input  logic [7:0]  day_units_char_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        date_valid_i,
  input  logic [11:0] year_value_i,
  input  logic [3:0]  month_value_i,
  input  logic [4:0]  day_of_month_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_cnt_o,
  output int unsigned good_dates_o,
  output int unsigned bad_dates_o
);

  // Month lengths of a common year
  localparam int unsigned DAYS_IN_MONTH [NUM_MONTHS] = '{
    31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
  };

  odd_result_t pending_dates_q [$];
  odd_result_t oldest_date;
  int unsigned mismatch_cnt;
  int unsigned good_cnt;
  int unsigned bad_cnt;

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Decode one CYYDDD field into a calendar date; all zero when rejected
  function automatic odd_result_t decode_ordinal(input logic [7:0] cc, input logic [7:0] yt,
                                                 input logic [7:0] yu, input logic [7:0] dh,
                                                 input logic [7:0] dt, input logic [7:0] du);
    odd_result_t r;
    int unsigned yr;
    int unsigned rest;
    int unsigned mlen;
    r = '0;
    if (!((cc == CHAR_SPACE) || is_numeral(cc)) || !is_numeral(yt) || !is_numeral(yu) ||
        !is_numeral(dh) || !is_numeral(dt) || !is_numeral(du)) begin
      return r;
    end
    if (cc == CHAR_SPACE) begin
      yr = YEAR_BASE_1900;
    end else begin
      yr = YEAR_BASE_2000 + 100 * (int'(cc) - int'(CHAR_ZERO));
    end
    yr = yr + 10 * (int'(yt) - int'(CHAR_ZERO)) + (int'(yu) - int'(CHAR_ZERO));
    rest = 100 * (int'(dh) - int'(CHAR_ZERO)) + 10 * (int'(dt) - int'(CHAR_ZERO))
         + (int'(du) - int'(CHAR_ZERO));
    // day zero is rejected
    if (rest == 0) begin
      return r;
    end
    // walk the months; a day equal to the month length stays in that month
    for (int m = 0; m < NUM_MONTHS; m++) begin
      mlen = DAYS_IN_MONTH[m];
      if ((m == 1) && (yr % 4 == 0)) begin
        mlen = mlen + 1;
      end
      if (rest <= mlen) begin
        r.date_valid   = 1'b1;
        r.year_value   = 12'(yr);
        r.month_value  = 4'(m + 1);
        r.day_of_month = 5'(rest);
        return r;
      end
      rest = rest - mlen;
    end
    // past the end of the year
    return '0;
  endfunction

  // Predict on input transfer, compare on result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_dates_q.delete();
      mismatch_cnt = 0;
      good_cnt     = 0;
      bad_cnt      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_dates_q.size() == 0) begin
          $error("result transfer with no date pending: valid=%0d year=%0d month=%0d day=%0d",
                 date_valid_i, year_value_i, month_value_i, day_of_month_i);
          mismatch_cnt++;
        end else begin
          oldest_date = pending_dates_q.pop_front();
          if (oldest_date.date_valid) good_cnt++; else bad_cnt++;
          if (date_valid_i !== oldest_date.date_valid) begin
            $error("date_valid: expected %0d, got %0d", oldest_date.date_valid, date_valid_i);
            mismatch_cnt++;
          end
          if (year_value_i !== oldest_date.year_value) begin
            $error("year_value: expected %0d, got %0d", oldest_date.year_value, year_value_i);
            mismatch_cnt++;
          end
          if (month_value_i !== oldest_date.month_value) begin
            $error("month_value: expected %0d, got %0d", oldest_date.month_value,
                   month_value_i);
            mismatch_cnt++;
          end
          if (day_of_month_i !== oldest_date.day_of_month) begin
            $error("day_of_month: expected %0d, got %0d", oldest_date.day_of_month,
                   day_of_month_i);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_dates_q.push_back(decode_ordinal(century_char_i, year_tens_char_i,
                                                 year_units_char_i, day_hundreds_char_i,
                                                 day_tens_char_i, day_units_char_i));
      end
    end
    // counts settle after the edge so readers never race the update
    fail_cnt_o    <= mismatch_cnt;
    pending_cnt_o <= pending_dates_q.size();
    good_dates_o  <= good_cnt;
    bad_dates_o   <= bad_cnt;
  end

endmodule

// ===== bench/ordinal_date_decoder_core_tb.sv =====
`timescale 1ns / 1ps

// Drives date fields into the decoder under varying sender gaps and
// receiver stalls; the checker next to the block does all comparing.
module ordinal_date_decoder_core_tb;
  import odd_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 550;
  localparam int unsigned HOLD_CYCLES      = 80;
  localparam int unsigned SETTLE_CYCLES    = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  century_char = '0;
  logic [7:0]  year_tens_char = '0;
  logic [7:0]  year_units_char = '0;
  logic [7:0]  day_hundreds_char = '0;
  logic [7:0]  day_tens_char = '0;
  logic [7:0]  day_units_char = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        date_valid;
  logic [11:0] year_value;
  logic [3:0]  month_value;
  logic [4:0]  day_of_month;
  logic        hold_rx = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned good_dates;
  int unsigned bad_dates;

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  ordinal_date_decoder_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .century_char_i     (century_char),
    .year_tens_char_i   (year_tens_char),
    .year_units_char_i  (year_units_char),
    .day_hundreds_char_i(day_hundreds_char),
    .day_tens_char_i    (day_tens_char),
    .day_units_char_i   (day_units_char),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .date_valid_o       (date_valid),
    .year_value_o       (year_value),
    .month_value_o      (month_value),
    .day_of_month_o     (day_of_month)
  );

  ordinal_date_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .century_char_i     (century_char),
    .year_tens_char_i   (year_tens_char),
    .year_units_char_i  (year_units_char),
    .day_hundreds_char_i(day_hundreds_char),
    .day_tens_char_i    (day_tens_char),
    .day_units_char_i   (day_units_char),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .date_valid_i       (date_valid),
    .year_value_i       (year_value),
    .month_value_i      (month_value),
    .day_of_month_i     (day_of_month),
    .fail_cnt_o         (fail_cnt),
    .pending_cnt_o      (pending_cnt),
    .good_dates_o       (good_dates),
    .bad_dates_o        (bad_dates)
  );

  // Receiver stall: random, or held high during a hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_rx || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one field, with random gaps first, until it is transferred
  task automatic send_date(input logic [47:0] chars);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    {century_char, year_tens_char, year_units_char,
     day_hundreds_char, day_tens_char, day_units_char} <= chars;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted date has come out
  task automatic drain_dates();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed fields with random content, some broken or pure noise
  function automatic logic [47:0] random_date();
    logic [7:0] ch [6];
    int unsigned kind;
    int unsigned doy;
    kind = $urandom_range(99);
    ch[0] = ($urandom_range(3) == 0) ? CHAR_SPACE : CHAR_ZERO + 8'($urandom_range(9));
    ch[1] = CHAR_ZERO + 8'($urandom_range(9));
    ch[2] = CHAR_ZERO + 8'($urandom_range(9));
    doy = (kind < 70) ? $urandom_range(366) : $urandom_range(999);
    ch[3] = CHAR_ZERO + 8'(doy / 100);
    ch[4] = CHAR_ZERO + 8'((doy / 10) % 10);
    ch[5] = CHAR_ZERO + 8'(doy % 10);
    if (kind >= 85) begin
      ch[$urandom_range(5)] = 8'($urandom_range(255));
    end
    if (kind >= 95) begin
      foreach (ch[k]) ch[k] = 8'($urandom_range(255));
    end
    return {ch[0], ch[1], ch[2], ch[3], ch[4], ch[5]};
  endfunction

  // Run limit
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: month edges, leap handling, year extremes, malformed chars
    send_date(" 00001");
    send_date(" 00031");
    send_date(" 00032");
    send_date(" 00060");
    send_date(" 01059");
    send_date(" 01060");
    send_date(" 00366");
    send_date(" 01365");
    send_date(" 01366");
    send_date(" 00367");
    send_date("999365");
    send_date("099999");
    send_date("012000");
    send_date("450335");
    send_date({6{8'h00}});
    send_date({6{8'hFF}});
    send_date("/00001");
    send_date(":00001");
    send_date("!00001");
    send_date({8'h1F, "00001"});
    send_date(" /0001");
    send_date(" 0:001");
    send_date(" 00/01");
    send_date(" 000:1");
    send_date("  0001");
    drain_dates();

    // Slow receiver
    send_idle_pct = 31;
    recv_idle_pct = 88;
    repeat (RANDOM_PER_PHASE) send_date(random_date());
    drain_dates();

    // Slow sender
    send_idle_pct = 88;
    recv_idle_pct = 31;
    repeat (RANDOM_PER_PHASE) send_date(random_date());
    drain_dates();

    // Full rate, with a long receiver hold-off at the start
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_rx <= 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
    join_none
    repeat (RANDOM_PER_PHASE) send_date(random_date());
    drain_dates();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d decoded dates and %0d rejected fields", good_dates, bad_dates);
    $display("Phases: slow receiver, slow sender, full rate after a long receiver hold-off");
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
